// File: design/lru_block_buffer_cache_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU block buffer cache
// Each macro names a concurrent check on i_clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define LBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LBC_ASSERT(label, clk, rst_n, prop, msg)
`define LBC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: design/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LRU block buffer cache package
// Shared types and constants for controller and datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned DEV_W    = 8;
    localparam int unsigned BLK_W    = 32;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned CNT_W    = 8;

    localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_REF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DROP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLW = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request word
        logic scan_clr; // reset scan accumulators
        logic scan;     // compare one entry
        logic commit;   // apply update, form result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan pointer on last entry
    } t_dp_stat;
endpackage

// File: design/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU block buffer cache controller
// Sequences load, entry scan and commit for one request word.
// ----------------------------------------------------------------------------
module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (i_stat.scan_last) n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // drive datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.scan_clr = o_cmd.load;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.commit   = (r_state == S_COMMIT);
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: design/lbc_dp.sv
// ----------------------------------------------------------------------------
// LRU block buffer cache datapath
// Entry state, serial tag/victim scan and update logic.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_cache_defines.svh"
module lbc_dp
    import lbc_pkg::*;
#(
    parameter int unsigned NUM_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [CMD_W-1:0]  i_cmd_code,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [IDX_W-1:0]  i_entry_index,
    output t_dp_stat          o_stat,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_entry_out,
    output logic              o_need_read,
    output logic [STAT_W-1:0] o_status
);
    localparam int unsigned EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [DEV_W-1:0] r_tag_dev [NUM_ENTRIES];
    logic [BLK_W-1:0] r_tag_blk [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0] r_cnt  [NUM_ENTRIES];
    logic [EW-1:0]    r_rank [NUM_ENTRIES];

    logic [CMD_W-1:0] r_cmd;
    logic [DEV_W-1:0] r_dev;
    logic [BLK_W-1:0] r_blk;
    logic [IDX_W-1:0] r_idx;

    logic [EW-1:0] r_ptr;
    logic          r_hit, r_free;
    logic [EW-1:0] r_hit_e, r_hit_rk, r_free_e, r_free_rk;

    logic          r_done;
    logic [IDX_W-1:0]  r_entry_out;
    logic          r_need;
    logic [STAT_W-1:0] r_status;

    logic          s_match, s_zero;
    logic          idx_ok;
    logic [EW-1:0] sel;
    logic [EW-1:0] rel_rk;
    logic          do_get, do_victim, do_mru;
    logic [CNT_W-1:0] sel_cnt;

    assign o_stat.scan_last = (r_ptr == EW'(NUM_ENTRIES - 1));

    // compare one entry per cycle
    assign s_match = (r_tag_dev[r_ptr] == r_dev) && (r_tag_blk[r_ptr] == r_blk);
    assign s_zero  = (r_cnt[r_ptr] == '0);

    // commit selection
    assign idx_ok    = ({3'b0, r_idx} < 8'(NUM_ENTRIES)) || (NUM_ENTRIES > 32);
    assign do_get    = (r_cmd == CMD_GET);
    assign do_victim = do_get && !r_hit && r_free;
    assign sel       = do_get ? (r_hit ? r_hit_e : r_free_e) : EW'(r_idx);
    assign sel_cnt   = r_cnt[sel];
    assign rel_rk    = r_rank[sel];
    assign do_mru    = !do_get && idx_ok && (r_cmd == CMD_RELEASE)
                       && (sel_cnt == CNT_W'(1));

    // capture request and run scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_code;
            r_dev <= i_device_id;
            r_blk <= i_block_number;
            r_idx <= i_entry_index;
        end
        if (!i_rst_n || i_cmd.scan_clr) begin
            r_ptr  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ptr <= r_ptr + EW'(1);
            if (s_match && (!r_hit || r_rank[r_ptr] < r_hit_rk)) begin
                r_hit    <= 1'b1;
                r_hit_e  <= r_ptr;
                r_hit_rk <= r_rank[r_ptr];
            end
            if (s_zero && (!r_free || r_rank[r_ptr] > r_free_rk)) begin
                r_free    <= 1'b1;
                r_free_e  <= r_ptr;
                r_free_rk <= r_rank[r_ptr];
            end
        end
    end

    // update entries and form the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_tag_dev[i] <= '0;
                r_tag_blk[i] <= '0;
                r_cnt[i]     <= '0;
                r_rank[i]    <= EW'(i);
            end
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_entry_out <= '0;
                r_need      <= 1'b0;
                r_status    <= ST_OK;
                if (do_get) begin
                    if (r_hit || r_free) begin
                        r_entry_out <= IDX_W'(sel);
                        r_need      <= do_victim ? 1'b1 : !r_valid[sel];
                        r_valid[sel] <= 1'b1;
                        if (do_victim) begin
                            r_tag_dev[sel] <= r_dev;
                            r_tag_blk[sel] <= r_blk;
                            r_cnt[sel]     <= CNT_W'(1);
                        end else if (sel_cnt != CNT_MAX) begin
                            r_cnt[sel] <= sel_cnt + CNT_W'(1);
                        end
                    end else begin
                        r_status <= ST_NO_FREE;
                    end
                end else begin
                    r_entry_out <= r_idx;
                    if (idx_ok) begin
                        if (r_cmd == CMD_ADD_REF) begin
                            if (sel_cnt != CNT_MAX) r_cnt[sel] <= sel_cnt + CNT_W'(1);
                        end else if (sel_cnt == '0) begin
                            r_status <= ST_UNDERFLW;
                        end else begin
                            r_cnt[sel] <= sel_cnt - CNT_W'(1);
                        end
                    end
                end
                // move an entry whose count a release takes to zero to the front
                if (do_mru) begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (r_rank[i] < rel_rk) r_rank[i] <= r_rank[i] + EW'(1);
                    end
                    r_rank[sel] <= '0;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_entry_out = r_entry_out;
    assign o_need_read = r_need;
    assign o_status    = r_status;

    `LBC_ASSERT_NEXT(a_done_after_commit, i_clk, i_rst_n, i_cmd.commit, r_done, "no result after commit")
    `LBC_ASSERT(a_no_scan_commit, i_clk, i_rst_n, !(i_cmd.scan && i_cmd.commit), "scan and commit overlap")
    `LBC_ASSERT_NEXT(a_victim_count, i_clk, i_rst_n, i_cmd.commit && do_victim, r_cnt[$past(sel)] == CNT_W'(1), "victim count not one")
endmodule

// File: design/lru_block_buffer_cache.sv
// After start is accepted, the controller scans every entry serially and then
// commits; o_valid is registered from the commit state. busy stays high
// through scan and commit, so a new word is taken only once it is idle;
// the serial tag/victim scan reads one entry per cycle.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears tags, counts and valid bits, and
// sets entry i to rank i; no clearing pass is needed.
// ----------------------------------------------------------------------------
// LRU block buffer cache top level
// Reference-counted, fully associative buffer cache with LRU replacement.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache
    import lbc_pkg::*;
#(
    parameter int unsigned NUM_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [IDX_W-1:0]  i_entry_index,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_entry_out,
    output logic              o_need_read,
    output logic [STAT_W-1:0] o_status
);
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    lbc_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cmd_code     (i_cmd),
        .i_device_id    (i_device_id),
        .i_block_number (i_block_number),
        .i_entry_index  (i_entry_index),
        .o_stat         (dp_stat),
        .o_done         (o_valid),
        .o_entry_out    (o_entry_out),
        .o_need_read    (o_need_read),
        .o_status       (o_status)
    );
endmodule
